// ===== rtl/core/rbsi_pkg.sv =====
package rbsi_pkg;

    typedef struct packed {
        logic neg0;
        logic neg1;
        logic sat0;
        logic sat1;
        logic nan;
        logic dir_pos;
    } rbsi_side_t;

    typedef struct packed {
        logic nan;
        logic dir_pos;
    } rbsi_flags_t;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

// ===== rtl/core/ray_box_slab_intersect.sv =====
// Segment against axis-aligned box test, one request per cycle when the output is not stalled.
// Each request passes through three axis lanes side by side, each with two pipelined restoring
// dividers producing one quotient bit per stage, then a merge stage that picks the entry face
// and checks the hit. The whole pipeline holds while a result waits under out_stall.
module ray_box_slab_intersect #(
    parameter int COORD_BITS      = 32,
    parameter int COORD_FRAC_BITS = 16,
    parameter int TIME_FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] box_min_x,
    input  logic signed [COORD_BITS-1:0] box_min_y,
    input  logic signed [COORD_BITS-1:0] box_min_z,
    input  logic signed [COORD_BITS-1:0] box_size_x,
    input  logic signed [COORD_BITS-1:0] box_size_y,
    input  logic signed [COORD_BITS-1:0] box_size_z,
    input  logic signed [COORD_BITS-1:0] ray_start_x,
    input  logic signed [COORD_BITS-1:0] ray_start_y,
    input  logic signed [COORD_BITS-1:0] ray_start_z,
    input  logic signed [COORD_BITS-1:0] ray_dir_x,
    input  logic signed [COORD_BITS-1:0] ray_dir_y,
    input  logic signed [COORD_BITS-1:0] ray_dir_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output logic [TIME_FRAC_BITS:0]      hit_time,
    output logic [2:0]                   hit_axis
);
    import rbsi_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int F     = TIME_FRAC_BITS;
    localparam int TW    = F + 3;
    localparam int DEPTH = F + 5;
    localparam int FRAC  = COORD_FRAC_BITS;

    logic              en;
    logic [DEPTH-1:0]  valid_reg, valid_next;
    logic signed [C-1:0]  lo [3], sz [3], st [3], dr [3];
    logic signed [TW-1:0] entry [3], exit_t [3];
    rbsi_flags_t          flags [3];

    assign lo = '{box_min_x, box_min_y, box_min_z};
    assign sz = '{box_size_x, box_size_y, box_size_z};
    assign st = '{ray_start_x, ray_start_y, ray_start_z};
    assign dr = '{ray_dir_x, ray_dir_y, ray_dir_z};

    // hold everything while the finished result is not taken
    assign en        = !(valid_reg[DEPTH-1] && out_stall) && (FRAC >= 0);
    assign in_stall  = !en;
    assign out_valid = valid_reg[DEPTH-1];

    assign valid_next = {valid_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    genvar a;
    generate
        for (a = 0; a < 3; a++)
        begin : g_lane
            rbsi_lane #(.C(C), .F(F)) u_lane (
                .clk    (clk),
                .en     (en),
                .lo     (lo[a]),
                .sz     (sz[a]),
                .st     (st[a]),
                .dir    (dr[a]),
                .entry  (entry[a]),
                .exit_t (exit_t[a]),
                .flags  (flags[a])
            );
        end
    endgenerate

    rbsi_merge #(.F(F)) u_merge (
        .clk      (clk),
        .en       (en),
        .entry    (entry),
        .exit_t   (exit_t),
        .flags    (flags),
        .hit      (hit),
        .hit_time (hit_time),
        .hit_axis (hit_axis)
    );

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (hit_time == '0 && hit_axis == 3'd0))
        else $error("miss result carries nonzero fields");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (hit_time <= ((F+1)'(1) << F)))
        else $error("hit time above one");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (hit_axis[2:1] != 2'd3))
        else $error("hit axis out of range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result");

endmodule

// ===== rtl/core/rbsi_div.sv =====
module rbsi_div #(
    parameter int DW = 32,
    parameter int QB = 17
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW:0]   num,
    input  logic [DW-1:0] den,
    output logic [QB-1:0] quo
);

    logic [DW-1:0] rem_reg [QB];
    logic [DW-1:0] den_reg [QB];
    logic [QB-1:0] q_reg   [QB];

    genvar i;
    generate
        for (i = 0; i < QB; i++)
        begin : g_stage
            logic [DW:0]   t;
            logic [DW:0]   diff;
            logic [DW-1:0] d;
            logic          ge;
            logic [QB-1:0] q_prev;
            logic [DW-1:0] rem_next;
            logic [QB-1:0] q_next;

            if (i == 0)
            begin : g_first
                assign t      = num;
                assign d      = den;
                assign q_prev = '0;
            end
            else
            begin : g_rest
                assign t      = {rem_reg[i-1], 1'b0};
                assign d      = den_reg[i-1];
                assign q_prev = q_reg[i-1];
            end

            assign ge       = t >= {1'b0, d};
            assign diff     = t - {1'b0, d};
            assign rem_next = ge ? diff[DW-1:0] : t[DW-1:0];
            assign q_next   = {q_prev[QB-2:0], ge};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                    den_reg[i] <= d;
                    q_reg[i]   <= q_next;
                end
            end
        end
    endgenerate

    assign quo = q_reg[QB-1];

endmodule

// ===== rtl/core/rbsi_lane.sv =====
module rbsi_lane #(
    parameter int C = 32,
    parameter int F = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [C-1:0]  lo,
    input  logic signed [C-1:0]  sz,
    input  logic signed [C-1:0]  st,
    input  logic signed [C-1:0]  dir,
    output logic signed [F+2:0]  entry,
    output logic signed [F+2:0]  exit_t,
    output rbsi_pkg::rbsi_flags_t flags
);
    import rbsi_pkg::*;

    localparam int NW = C + 2;
    localparam int QB = F + 1;
    localparam int TW = F + 3;
    localparam logic signed [TW-1:0] T_SAT = TW'(1) <<< (F + 1);

    logic signed [NW-1:0] num0_reg, num1_reg;
    logic signed [C-1:0]  dir_reg;
    logic [NW-1:0]        n0mag, n1mag;
    logic [C-1:0]         dmag;
    rbsi_side_t           side_next;
    rbsi_side_t           side_reg [QB+1];
    logic [C:0]           dnum0_reg, dnum1_reg;
    logic [C-1:0]         dden_reg;
    logic [QB-1:0]        q0, q1;
    logic signed [TW-1:0] mag0, mag1, t0, t1;
    logic signed [TW-1:0] entry_reg, exit_reg;
    rbsi_flags_t          flags_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num0_reg <= NW'(lo) - NW'(st);
            num1_reg <= NW'(lo) + NW'(sz) - NW'(st);
            dir_reg  <= dir;
        end
    end

    assign n0mag = num0_reg[NW-1] ? NW'(-num0_reg) : NW'(num0_reg);
    assign n1mag = num1_reg[NW-1] ? NW'(-num1_reg) : NW'(num1_reg);
    assign dmag  = dir_reg[C-1] ? C'(-dir_reg) : C'(dir_reg);

    always_comb
    begin
        side_next.neg0    = num0_reg[NW-1] ^ dir_reg[C-1];
        side_next.neg1    = num1_reg[NW-1] ^ dir_reg[C-1];
        side_next.sat0    = ((dmag == '0) && (n0mag != '0)) || (n0mag >= {1'b0, dmag, 1'b0});
        side_next.sat1    = ((dmag == '0) && (n1mag != '0)) || (n1mag >= {1'b0, dmag, 1'b0});
        side_next.nan     = (dmag == '0) && ((n0mag == '0) || (n1mag == '0));
        side_next.dir_pos = !dir_reg[C-1] && (dir_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dnum0_reg   <= n0mag[C:0];
            dnum1_reg   <= n1mag[C:0];
            dden_reg    <= dmag;
            side_reg[0] <= side_next;
            for (int k = 1; k <= QB; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    rbsi_div #(.DW(C), .QB(QB)) u_div0 (
        .clk (clk),
        .en  (en),
        .num (dnum0_reg),
        .den (dden_reg),
        .quo (q0)
    );

    rbsi_div #(.DW(C), .QB(QB)) u_div1 (
        .clk (clk),
        .en  (en),
        .num (dnum1_reg),
        .den (dden_reg),
        .quo (q1)
    );

    assign mag0 = side_reg[QB].sat0 ? T_SAT : TW'(q0);
    assign mag1 = side_reg[QB].sat1 ? T_SAT : TW'(q1);
    assign t0   = side_reg[QB].neg0 ? -mag0 : mag0;
    assign t1   = side_reg[QB].neg1 ? -mag1 : mag1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg         <= (t0 > t1) ? t1 : t0;
            exit_reg          <= (t0 > t1) ? t0 : t1;
            flags_reg.nan     <= side_reg[QB].nan;
            flags_reg.dir_pos <= side_reg[QB].dir_pos;
        end
    end

    assign entry  = entry_reg;
    assign exit_t = exit_reg;
    assign flags  = flags_reg;

endmodule

// ===== rtl/core/rbsi_merge.sv =====
module rbsi_merge #(
    parameter int F = 16
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [F+2:0]   entry  [3],
    input  logic signed [F+2:0]   exit_t [3],
    input  rbsi_pkg::rbsi_flags_t flags  [3],
    output logic                  hit,
    output logic [F:0]            hit_time,
    output logic [2:0]            hit_axis
);
    import rbsi_pkg::*;

    localparam int TW = F + 3;
    localparam logic signed [TW-1:0] T_ONE = TW'(1) <<< F;

    logic [1:0]           axis;
    logic signed [TW-1:0] t_in, t_out01, t_out;
    logic                 dir_pos, any_nan, ok;
    logic                 hit_reg;
    logic [F:0]           time_reg;
    logic [2:0]           axis_reg;

    always_comb
    begin
        if (entry[0] > entry[1])
        begin
            axis = (entry[0] > entry[2]) ? AXIS_X : AXIS_Z;
        end
        else
        begin
            axis = (entry[1] > entry[2]) ? AXIS_Y : AXIS_Z;
        end
        t_in    = entry[axis];
        dir_pos = flags[axis].dir_pos;
        t_out01 = (exit_t[1] < exit_t[0]) ? exit_t[1] : exit_t[0];
        t_out   = (exit_t[2] < t_out01) ? exit_t[2] : t_out01;
        any_nan = flags[0].nan || flags[1].nan || flags[2].nan;
        ok      = !any_nan && (t_in < t_out) && (t_in >= 0) && (t_in <= T_ONE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= ok;
            time_reg <= ok ? t_in[F:0] : '0;
            axis_reg <= ok ? {axis, !dir_pos} : 3'd0;
        end
    end

    assign hit      = hit_reg;
    assign hit_time = time_reg;
    assign hit_axis = axis_reg;

endmodule
